FILE: rtl/bpt_pkg.sv
// Package for the bidirectional position trigger.
// Holds the sweep phase type, register indexes and payload widths; no dependencies.
`default_nettype none

package bpt_pkg;

  localparam int unsigned PosW   = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CountW = 32;
  localparam int unsigned SweepW = 17;
  localparam int unsigned WideW  = 19;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_UP       = 3'd1,
    PH_WAIT_TOP = 3'd2,
    PH_DOWN     = 3'd3,
    PH_WAIT_BOT = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    REG_LOW_BOUND   = 2'd0,
    REG_HIGH_BOUND  = 2'd1,
    REG_STEP_SIZE   = 2'd2,
    REG_SCAN_TARGET = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic                        trigger_level;
    logic                        fired;
    logic [CountW-1:0]           trigger_count;
    logic [SweepW-1:0]           sweeps_done;
    logic                        busy_res;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/bpt_req_if.sv
// Request channel of the position trigger: start or position sample.
// Depends on bpt_pkg for the position width.
`default_nettype none

interface bpt_req_if;
  import bpt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic signed [PosW-1:0] position;

  modport source (output valid, output req_type, output position, input ready);
  modport sink   (input valid, input req_type, input position, output ready);
endinterface

`default_nettype wire

FILE: rtl/bpt_res_if.sv
// Result channel of the position trigger: line level, counts and run status.
// Depends on bpt_pkg for the count widths.
`default_nettype none

interface bpt_res_if;
  import bpt_pkg::*;

  logic              valid;
  logic              ready;
  logic              trigger_level;
  logic              fired;
  logic [CountW-1:0] trigger_count;
  logic [SweepW-1:0] sweeps_done;
  logic              busy_res;

  modport source (output valid, output trigger_level, output fired, output trigger_count,
                  output sweeps_done, output busy_res, input ready);
  modport sink   (input valid, input trigger_level, input fired, input trigger_count,
                  input sweeps_done, input busy_res, output ready);
endinterface

`default_nettype wire

FILE: rtl/bidirectional_position_trigger_core.sv
// Top level of the bidirectional position trigger: APB register file, input register,
// sweep compare logic and result register. Depends on bpt_pkg, bpt_req_if, bpt_res_if.
`default_nettype none

// Position-compare trigger for a stage that scans back and forth. A start transaction
// clears the line and counts and, unless scan_target is zero, arms an upward sweep at
// low_bound; each position sample toggles the line when the position reaches the next
// trigger point, sweeping up to high_bound, waiting for an overshoot of two steps, then
// sweeping down, in pairs until at least scan_target sweeps are done. One transaction is
// taken every clock unless stalled. Each request passes the input and then the result
// register, with the compare and next-point update in between. Ready drops only while
// both registers are full and the result side stalls. Registers sit at byte addresses
// 0, 4, 8 and 12 and are read live, so write them only while the block is idle.
module bidirectional_position_trigger_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  bpt_req_if.sink                    req_i,
  bpt_res_if.source                  res_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [bpt_pkg::AddrW-1:0] paddr,
  input  wire logic [bpt_pkg::DataW-1:0] pwdata,
  output logic [bpt_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import bpt_pkg::*;

  logic [CfgW-1:0] low_q, high_q, step_q, target_q;

  logic                   in_vld_q;
  logic                   in_req_q;
  logic signed [PosW-1:0] in_pos_q;

  phase_e             phase_q, phase_d;
  logic               line_q, line_d;
  logic [CfgW-1:0]    next_q, next_d;
  logic [SweepW-1:0]  sweep_q, sweep_d;
  logic [CountW-1:0]  count_q, count_d;
  logic               fired_d;

  logic  out_vld_q;
  res_t  res_q;

  logic  adv;
  logic  cfg_wr;
  reg_idx_e cfg_idx;

  logic signed [WideW-1:0] pos_w, np_w, step_w, hi_w, lo_w;
  logic signed [WideW-1:0] top_wait, bot_wait, np_up, np_dn;
  logic [SweepW-1:0]       sweep_inc;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q    <= '0;
      high_q   <= '1;
      step_q   <= CfgW'(1);
      target_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LOW_BOUND:   low_q    <= pwdata[CfgW-1:0];
        REG_HIGH_BOUND:  high_q   <= pwdata[CfgW-1:0];
        REG_STEP_SIZE:   step_q   <= pwdata[CfgW-1:0];
        REG_SCAN_TARGET: target_q <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LOW_BOUND:   prdata = DataW'(low_q);
      REG_HIGH_BOUND:  prdata = DataW'(high_q);
      REG_STEP_SIZE:   prdata = DataW'(step_q);
      REG_SCAN_TARGET: prdata = DataW'(target_q);
      default:         prdata = '0;
    endcase
  end

  // handshake
  assign adv         = !out_vld_q || res_o.ready;
  assign req_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_req_q <= req_i.req_type;
      in_pos_q <= req_i.position;
    end
  end

  // wide compare arithmetic
  assign pos_w     = WideW'(in_pos_q);
  assign np_w      = $signed({3'b000, next_q});
  assign step_w    = $signed({3'b000, step_q});
  assign hi_w      = $signed({3'b000, high_q});
  assign lo_w      = $signed({3'b000, low_q});
  assign top_wait  = hi_w + (step_w <<< 1);
  assign bot_wait  = lo_w - (step_w <<< 1);
  assign np_up     = np_w + step_w;
  assign np_dn     = np_w - step_w;
  assign sweep_inc = sweep_q + SweepW'(1);

  always_comb begin
    phase_d = phase_q;
    line_d  = line_q;
    next_d  = next_q;
    sweep_d = sweep_q;
    count_d = count_q;
    fired_d = 1'b0;
    if (in_req_q) begin
      line_d  = 1'b0;
      count_d = '0;
      sweep_d = '0;
      next_d  = low_q;
      phase_d = (target_q == '0) ? PH_IDLE : PH_UP;
    end else begin
      case (phase_q)
        PH_UP: begin
          if (pos_w >= np_w) begin
            line_d  = !line_q;
            count_d = count_q + CountW'(1);
            fired_d = 1'b1;
            if (np_up > hi_w) begin
              next_d  = high_q;
              sweep_d = sweep_inc;
              phase_d = (pos_w >= top_wait) ? PH_DOWN : PH_WAIT_TOP;
            end else begin
              next_d = np_up[CfgW-1:0];
            end
          end
        end
        PH_WAIT_TOP: begin
          if (pos_w >= top_wait) begin
            phase_d = PH_DOWN;
          end
        end
        PH_DOWN: begin
          if (pos_w <= np_w) begin
            line_d  = !line_q;
            count_d = count_q + CountW'(1);
            fired_d = 1'b1;
            if (np_dn < lo_w) begin
              next_d  = low_q;
              sweep_d = sweep_inc;
              if (sweep_inc > SweepW'(target_q)) begin
                phase_d = PH_IDLE;
                line_d  = 1'b0;
              end else if (pos_w <= bot_wait) begin
                if (sweep_inc < SweepW'(target_q)) begin
                  phase_d = PH_UP;
                end else begin
                  phase_d = PH_IDLE;
                  line_d  = 1'b0;
                end
              end else begin
                phase_d = PH_WAIT_BOT;
              end
            end else begin
              next_d = np_dn[CfgW-1:0];
            end
          end
        end
        PH_WAIT_BOT: begin
          if (pos_w <= bot_wait) begin
            if (sweep_q < SweepW'(target_q)) begin
              phase_d = PH_UP;
            end else begin
              phase_d = PH_IDLE;
              line_d  = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      line_q    <= 1'b0;
      next_q    <= '0;
      sweep_q   <= '0;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
      if (in_vld_q) begin
        phase_q <= phase_d;
        line_q  <= line_d;
        next_q  <= next_d;
        sweep_q <= sweep_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_vld_q) begin
      res_q.trigger_level <= line_d;
      res_q.fired         <= fired_d;
      res_q.trigger_count <= count_d;
      res_q.sweeps_done   <= sweep_d;
      res_q.busy_res      <= (phase_d != PH_IDLE);
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.trigger_level = res_q.trigger_level;
  assign res_o.fired         = res_q.fired;
  assign res_o.trigger_count = res_q.trigger_count;
  assign res_o.sweeps_done   = res_q.sweeps_done;
  assign res_o.busy_res      = res_q.busy_res;

  a_idle_line_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> !line_q)
    else $error("trigger line high while no run is active");

  a_full_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !res_o.ready) |-> !req_i.ready)
    else $error("request taken while both stages are full and stalled");

  a_item_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_vld_q) |=> out_vld_q)
    else $error("registered request did not produce a result");

endmodule

`default_nettype wire
